>>> rtl/core/sei_pkg.sv
package sei_pkg;

    // widths of the datapath
    localparam int COORD_W    = 32;
    localparam int CLR_W      = 31;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int C2_W       = 2 * CLR_W;
    localparam int MAG_W      = SUM_W - 1;
    localparam int WIDE_W     = 2 * MAG_W;
    localparam int NUM_DIFF   = 6;
    localparam int NUM_OPS    = 15;
    localparam int NUM_STAGES = 8;

    // squared raw length at or below which a segment counts as a point
    localparam logic signed [SUM_W-1:0] SHORT_LEN2_MAX   = 67'sd4294;
    // determinant magnitude at or below which segments count as parallel
    localparam logic signed [SUM_W-1:0] PARALLEL_DET_MAX = 67'sd42;

    typedef logic signed [SUM_W-1:0] t_sum;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx REG_DOOR_START_X = 2'd0;
    localparam t_cfg_idx REG_DOOR_START_Y = 2'd1;
    localparam t_cfg_idx REG_DOOR_END_X   = 2'd2;
    localparam t_cfg_idx REG_DOOR_END_Y   = 2'd3;

    // difference vectors
    localparam int DI_A  = 0;  // lane start - door start
    localparam int DI_B  = 1;  // lane start - door end
    localparam int DI_C  = 2;  // lane end - door start
    localparam int DI_D  = 3;  // lane end - door end
    localparam int DI_DD = 4;  // door end - door start
    localparam int DI_DL = 5;  // lane end - lane start

    // dot and cross results handed from front to back
    localparam int OP_DIST_A = 0;
    localparam int OP_DIST_B = 1;
    localparam int OP_DIST_C = 2;
    localparam int OP_DIST_D = 3;
    localparam int OP_DEN_D  = 4;
    localparam int OP_DEN_L  = 5;
    localparam int OP_TN_A   = 6;
    localparam int OP_TN_B   = 7;
    localparam int OP_DOT_AL = 8;
    localparam int OP_DOT_BL = 9;
    localparam int OP_CR_A   = 10;
    localparam int OP_CR_B   = 11;
    localparam int OP_CR_LA  = 12;
    localparam int OP_CR_LB  = 13;
    localparam int OP_DET    = 14;

    // decisions carried down the back end
    typedef struct packed {
        logic       ep_near;
        logic [3:0] seg_ok;
        logic       cross_hit;
    } t_flags;

endpackage

>>> rtl/core/sei_front.sv
module sei_front import sei_pkg::*; (
    input  logic                      i_clk,
    input  logic [2:0]                i_en,
    input  logic signed [COORD_W-1:0] i_p0x,
    input  logic signed [COORD_W-1:0] i_p0y,
    input  logic signed [COORD_W-1:0] i_p1x,
    input  logic signed [COORD_W-1:0] i_p1y,
    input  logic signed [COORD_W-1:0] i_q0x,
    input  logic signed [COORD_W-1:0] i_q0y,
    input  logic signed [COORD_W-1:0] i_q1x,
    input  logic signed [COORD_W-1:0] i_q1y,
    input  logic [CLR_W-1:0]          i_clr,
    output t_sum                      o_sum [NUM_OPS],
    output logic [C2_W-1:0]           o_c2
);

    // operand vectors of each dot or cross product
    localparam int OP_L [NUM_OPS] = '{DI_A, DI_B, DI_C, DI_D, DI_DD, DI_DL, DI_A, DI_C,
                                      DI_A, DI_B, DI_DD, DI_DD, DI_DL, DI_DL, DI_DL};
    localparam int OP_R [NUM_OPS] = '{DI_A, DI_B, DI_C, DI_D, DI_DD, DI_DL, DI_DD, DI_DD,
                                      DI_DL, DI_DL, DI_A, DI_C, DI_A, DI_B, DI_DD};
    localparam bit OP_X [NUM_OPS] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                      1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

    logic signed [DIFF_W-1:0] n_dx [NUM_DIFF];
    logic signed [DIFF_W-1:0] n_dy [NUM_DIFF];
    logic signed [DIFF_W-1:0] r_dx [NUM_DIFF];
    logic signed [DIFF_W-1:0] r_dy [NUM_DIFF];
    logic [CLR_W-1:0]         r_clr;
    logic signed [PROD_W-1:0] r_pa [NUM_OPS];
    logic signed [PROD_W-1:0] r_pb [NUM_OPS];
    logic [C2_W-1:0]          r_c2;
    logic [C2_W-1:0]          r_c2_q;
    t_sum                     r_sum [NUM_OPS];

    // difference stage
    always_comb begin
        n_dx[DI_A]  = DIFF_W'(i_p0x) - DIFF_W'(i_q0x);
        n_dy[DI_A]  = DIFF_W'(i_p0y) - DIFF_W'(i_q0y);
        n_dx[DI_B]  = DIFF_W'(i_p0x) - DIFF_W'(i_q1x);
        n_dy[DI_B]  = DIFF_W'(i_p0y) - DIFF_W'(i_q1y);
        n_dx[DI_C]  = DIFF_W'(i_p1x) - DIFF_W'(i_q0x);
        n_dy[DI_C]  = DIFF_W'(i_p1y) - DIFF_W'(i_q0y);
        n_dx[DI_D]  = DIFF_W'(i_p1x) - DIFF_W'(i_q1x);
        n_dy[DI_D]  = DIFF_W'(i_p1y) - DIFF_W'(i_q1y);
        n_dx[DI_DD] = DIFF_W'(i_q1x) - DIFF_W'(i_q0x);
        n_dy[DI_DD] = DIFF_W'(i_q1y) - DIFF_W'(i_q0y);
        n_dx[DI_DL] = DIFF_W'(i_p1x) - DIFF_W'(i_p0x);
        n_dy[DI_DL] = DIFF_W'(i_p1y) - DIFF_W'(i_p0y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_clr <= i_clr;
        end
    end

    // product stage, then pairwise sums
    for (genvar k = 0; k < NUM_OPS; k++) begin : g_op
        always_ff @(posedge i_clk) begin
            if (i_en[1]) begin
                if (OP_X[k]) begin
                    r_pa[k] <= PROD_W'(r_dx[OP_L[k]]) * PROD_W'(r_dy[OP_R[k]]);
                    r_pb[k] <= PROD_W'(r_dy[OP_L[k]]) * PROD_W'(r_dx[OP_R[k]]);
                end else begin
                    r_pa[k] <= PROD_W'(r_dx[OP_L[k]]) * PROD_W'(r_dx[OP_R[k]]);
                    r_pb[k] <= PROD_W'(r_dy[OP_L[k]]) * PROD_W'(r_dy[OP_R[k]]);
                end
            end
            if (i_en[2]) begin
                if (OP_X[k]) begin
                    r_sum[k] <= SUM_W'(r_pa[k]) - SUM_W'(r_pb[k]);
                end else begin
                    r_sum[k] <= SUM_W'(r_pa[k]) + SUM_W'(r_pb[k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_c2 <= C2_W'(r_clr) * C2_W'(r_clr);
        end
        if (i_en[2]) begin
            r_c2_q <= r_c2;
        end
    end

    assign o_sum = r_sum;
    assign o_c2  = r_c2_q;

endmodule

>>> rtl/core/sei_back.sv
module sei_back import sei_pkg::*; (
    input  logic            i_clk,
    input  logic [3:0]      i_en,
    input  t_sum            i_sum [NUM_OPS],
    input  logic [C2_W-1:0] i_c2,
    output logic            o_hit
);

    localparam int MAG_LO_W = 34;
    localparam int MAG_HI_W = MAG_W - MAG_LO_W;
    localparam int C2_LO_W  = C2_W / 2;
    localparam int C2_HI_W  = C2_W - C2_LO_W;

    function automatic logic in_unit(input t_sum n, input t_sum det);
        if (det >= 0) begin
            return (n >= 0) && (n <= det);
        end
        return (n >= det) && (n <= 0);
    endfunction

    t_sum             c2e;
    t_sum             tn_c;
    t_sum             tn_d;
    logic             par;
    t_flags           n_flags;
    logic [MAG_W-1:0] n_mag [4];

    t_flags           r_flags5, r_flags6, r_flags7;
    logic [MAG_W-1:0] r_mag [4];
    logic [MAG_W-1:0] r_den [2];
    logic [C2_W-1:0]  r_c2;

    logic [2*MAG_HI_W-1:0]        r_hh [4];
    logic [MAG_HI_W+MAG_LO_W-1:0] r_hl [4];
    logic [2*MAG_LO_W-1:0]        r_ll [4];
    logic [C2_HI_W+MAG_HI_W-1:0]  r_dhh [2];
    logic [C2_HI_W+MAG_LO_W-1:0]  r_dhl [2];
    logic [C2_LO_W+MAG_HI_W-1:0]  r_dlh [2];
    logic [C2_LO_W+MAG_LO_W-1:0]  r_dll [2];

    logic [WIDE_W-1:0] r_cr2 [4];
    logic [WIDE_W-1:0] r_cd [2];
    logic              r_hit;

    // decision stage: endpoint, projection and crossing tests
    always_comb begin
        c2e  = $signed(SUM_W'(i_c2));
        tn_c = -i_sum[OP_DOT_AL];
        tn_d = -i_sum[OP_DOT_BL];
        par  = (i_sum[OP_DET] <= PARALLEL_DET_MAX) && (i_sum[OP_DET] >= -PARALLEL_DET_MAX);

        n_flags.ep_near = (i_sum[OP_DIST_A] <= c2e) || (i_sum[OP_DIST_B] <= c2e) ||
                          (i_sum[OP_DIST_C] <= c2e) || (i_sum[OP_DIST_D] <= c2e);
        n_flags.seg_ok[0] = (i_sum[OP_DEN_D] > SHORT_LEN2_MAX) && (i_sum[OP_TN_A] > 0) &&
                            (i_sum[OP_TN_A] < i_sum[OP_DEN_D]);
        n_flags.seg_ok[1] = (i_sum[OP_DEN_D] > SHORT_LEN2_MAX) && (i_sum[OP_TN_B] > 0) &&
                            (i_sum[OP_TN_B] < i_sum[OP_DEN_D]);
        n_flags.seg_ok[2] = (i_sum[OP_DEN_L] > SHORT_LEN2_MAX) && (tn_c > 0) &&
                            (tn_c < i_sum[OP_DEN_L]);
        n_flags.seg_ok[3] = (i_sum[OP_DEN_L] > SHORT_LEN2_MAX) && (tn_d > 0) &&
                            (tn_d < i_sum[OP_DEN_L]);
        n_flags.cross_hit = !par && in_unit(i_sum[OP_CR_A], i_sum[OP_DET]) &&
                            in_unit(i_sum[OP_CR_LA], i_sum[OP_DET]);

        for (int i = 0; i < 4; i++) begin
            if (i_sum[OP_CR_A + i] < 0) begin
                n_mag[i] = MAG_W'(-i_sum[OP_CR_A + i]);
            end else begin
                n_mag[i] = MAG_W'(i_sum[OP_CR_A + i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_flags5 <= n_flags;
            r_mag    <= n_mag;
            r_den[0] <= MAG_W'(i_sum[OP_DEN_D]);
            r_den[1] <= MAG_W'(i_sum[OP_DEN_L]);
            r_c2     <= i_c2;
        end
        if (i_en[1]) begin
            r_flags6 <= r_flags5;
        end
        if (i_en[2]) begin
            r_flags7 <= r_flags6;
        end
    end

    // partial products of the squared cross terms
    for (genvar i = 0; i < 4; i++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (i_en[1]) begin
                r_hh[i] <= (2*MAG_HI_W)'(r_mag[i][MAG_W-1:MAG_LO_W]) *
                           (2*MAG_HI_W)'(r_mag[i][MAG_W-1:MAG_LO_W]);
                r_hl[i] <= (MAG_HI_W+MAG_LO_W)'(r_mag[i][MAG_W-1:MAG_LO_W]) *
                           (MAG_HI_W+MAG_LO_W)'(r_mag[i][MAG_LO_W-1:0]);
                r_ll[i] <= (2*MAG_LO_W)'(r_mag[i][MAG_LO_W-1:0]) *
                           (2*MAG_LO_W)'(r_mag[i][MAG_LO_W-1:0]);
            end
            if (i_en[2]) begin
                r_cr2[i] <= (WIDE_W'(r_hh[i]) << (2*MAG_LO_W)) +
                            (WIDE_W'(r_hl[i]) << (MAG_LO_W+1)) + WIDE_W'(r_ll[i]);
            end
        end
    end

    // partial products of clearance squared times segment length squared
    for (genvar j = 0; j < 2; j++) begin : g_cd
        always_ff @(posedge i_clk) begin
            if (i_en[1]) begin
                r_dhh[j] <= (C2_HI_W+MAG_HI_W)'(r_c2[C2_W-1:C2_LO_W]) *
                            (C2_HI_W+MAG_HI_W)'(r_den[j][MAG_W-1:MAG_LO_W]);
                r_dhl[j] <= (C2_HI_W+MAG_LO_W)'(r_c2[C2_W-1:C2_LO_W]) *
                            (C2_HI_W+MAG_LO_W)'(r_den[j][MAG_LO_W-1:0]);
                r_dlh[j] <= (C2_LO_W+MAG_HI_W)'(r_c2[C2_LO_W-1:0]) *
                            (C2_LO_W+MAG_HI_W)'(r_den[j][MAG_W-1:MAG_LO_W]);
                r_dll[j] <= (C2_LO_W+MAG_LO_W)'(r_c2[C2_LO_W-1:0]) *
                            (C2_LO_W+MAG_LO_W)'(r_den[j][MAG_LO_W-1:0]);
            end
            if (i_en[2]) begin
                r_cd[j] <= (WIDE_W'(r_dhh[j]) << (C2_LO_W+MAG_LO_W)) +
                           (WIDE_W'(r_dhl[j]) << C2_LO_W) +
                           (WIDE_W'(r_dlh[j]) << MAG_LO_W) + WIDE_W'(r_dll[j]);
            end
        end
    end

    // final compare and merge
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_hit <= r_flags7.ep_near || r_flags7.cross_hit ||
                     (r_flags7.seg_ok[0] && (r_cr2[0] <= r_cd[0])) ||
                     (r_flags7.seg_ok[1] && (r_cr2[1] <= r_cd[0])) ||
                     (r_flags7.seg_ok[2] && (r_cr2[2] <= r_cd[1])) ||
                     (r_flags7.seg_ok[3] && (r_cr2[3] <= r_cd[1]));
        end
    end

    assign o_hit = r_hit;

endmodule

>>> rtl/core/segment_envelope_intersection_core.sv
// Segment envelope intersection core. Each request carries a lane segment and a
// clearance; the result says whether the lane crosses the door segment held in the
// four door registers, or whether any of the four endpoints lies within the clearance
// of the other segment (true clamped point-to-segment distance, compared squared and
// exactly on the raw Q15.16 values). The core is an eight-stage pipeline: input
// register, differences, 33x33 products, dot and cross sums, decision tests, split
// partial products of the wide squares, wide sums, and the final compare into the
// output register. A request goes in every clock unless stalled; stall passes back
// combinationally through full stages only, so empty stages keep filling while a
// result waits. Door registers must only be written while the pipeline is empty.
module segment_envelope_intersection_core import sei_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [COORD_W-1:0] i_lane_start_x,
    input  logic signed [COORD_W-1:0] i_lane_start_y,
    input  logic signed [COORD_W-1:0] i_lane_end_x,
    input  logic signed [COORD_W-1:0] i_lane_end_y,
    input  logic [CLR_W-1:0]          i_clearance,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_hit,
    // configuration write port
    input  logic                      i_cfg_we,
    input  t_cfg_idx                  i_cfg_index,
    input  logic [COORD_W-1:0]        i_cfg_data
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] stage_rdy;

    logic signed [COORD_W-1:0] r_door_sx, r_door_sy, r_door_ex, r_door_ey;
    logic signed [COORD_W-1:0] r_p0x, r_p0y, r_p1x, r_p1y;
    logic [CLR_W-1:0]          r_clr;

    t_sum            sum [NUM_OPS];
    logic [C2_W-1:0] c2;

    // a stage may load when it is empty or its successor moves on
    always_comb begin
        stage_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];
        end
    end

    assign o_in_stall  = !stage_rdy[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // door registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door_sx <= '0;
            r_door_sy <= '0;
            r_door_ex <= '0;
            r_door_ey <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DOOR_START_X: r_door_sx <= i_cfg_data;
                REG_DOOR_START_Y: r_door_sy <= i_cfg_data;
                REG_DOOR_END_X:   r_door_ex <= i_cfg_data;
                REG_DOOR_END_Y:   r_door_ey <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r_p0x <= i_lane_start_x;
            r_p0y <= i_lane_start_y;
            r_p1x <= i_lane_end_x;
            r_p1y <= i_lane_end_y;
            r_clr <= i_clearance;
        end
    end

    // differences, products and sums
    sei_front u_front (
        .i_clk (i_clk),
        .i_en  (stage_rdy[3:1]),
        .i_p0x (r_p0x),
        .i_p0y (r_p0y),
        .i_p1x (r_p1x),
        .i_p1y (r_p1y),
        .i_q0x (r_door_sx),
        .i_q0y (r_door_sy),
        .i_q1x (r_door_ex),
        .i_q1y (r_door_ey),
        .i_clr (r_clr),
        .o_sum (sum),
        .o_c2  (c2)
    );

    // tests, wide squares and final decision
    sei_back u_back (
        .i_clk (i_clk),
        .i_en  (stage_rdy[7:4]),
        .i_sum (sum),
        .i_c2  (c2),
        .o_hit (o_hit)
    );

endmodule

>>> rtl/core/sei_checker.sv
module sei_checker import sei_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_hit
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hit))
        else $error("result changed while stalled");

    // an empty output stage lets requests in
    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("request stalled with empty output");

    // stall back pressure only comes from the result side
    a_flow_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("request stalled while results flow");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind segment_envelope_intersection_core sei_checker u_sei_checker (.*);

>>> dv/tb_segment_envelope_intersection_core.sv
`timescale 1ns / 100ps

module tb_segment_envelope_intersection_core;
    import sei_pkg::*;

    // exact predictor and in-order store of expected hit flags
    class hit_scoreboard;
        logic signed [COORD_W-1:0] door[4];
        bit                        hit_queue[$];
        int                        errors;

        function new();
            foreach (door[k]) door[k] = '0;
            errors = 0;
        endfunction

        // wide enough for squared cross products times clearance terms
        function logic signed [159:0] wx(longint v);
            return 160'(v);
        endfunction

        function logic signed [159:0] dot2(longint ax, longint ay, longint bx, longint by);
            return wx(ax) * wx(bx) + wx(ay) * wx(by);
        endfunction

        function logic signed [159:0] cross2(longint ax, longint ay, longint bx, longint by);
            return wx(ax) * wx(by) - wx(ay) * wx(bx);
        endfunction

        // point q within clearance of segment a-b, clamped to the segment
        function bit near_seg(longint qx, longint qy, longint ax, longint ay,
                              longint bx, longint by, logic signed [159:0] c2);
            logic signed [159:0] den, tn, cr;
            if (dot2(qx - ax, qy - ay, qx - ax, qy - ay) <= c2) return 1;
            if (dot2(qx - bx, qy - by, qx - bx, qy - by) <= c2) return 1;
            den = dot2(bx - ax, by - ay, bx - ax, by - ay);
            if (den <= wx(longint'(SHORT_LEN2_MAX))) return 0;
            tn = dot2(qx - ax, qy - ay, bx - ax, by - ay);
            if (tn <= 0 || den <= tn) return 0;
            cr = cross2(bx - ax, by - ay, qx - ax, qy - ay);
            return (cr * cr) <= (c2 * den);
        endfunction

        function bit in_span(logic signed [159:0] n, logic signed [159:0] d);
            if (d >= 0) return (n >= 0) && (n <= d);
            return (n >= d) && (n <= 0);
        endfunction

        function bit predict_hit(logic signed [31:0] p0x, logic signed [31:0] p0y,
                                 logic signed [31:0] p1x, logic signed [31:0] p1y,
                                 logic [CLR_W-1:0] clr);
            logic signed [159:0] c2, det;
            longint a0x, a0y, a1x, a1y;
            longint q0x, q0y, q1x, q1y, rx, ry, sx, sy, wxx, wyy;
            a0x = longint'(p0x);
            a0y = longint'(p0y);
            a1x = longint'(p1x);
            a1y = longint'(p1y);
            q0x = longint'(door[REG_DOOR_START_X]);
            q0y = longint'(door[REG_DOOR_START_Y]);
            q1x = longint'(door[REG_DOOR_END_X]);
            q1y = longint'(door[REG_DOOR_END_Y]);
            c2 = wx(longint'(clr)) * wx(longint'(clr));
            if (near_seg(a0x, a0y, q0x, q0y, q1x, q1y, c2) ||
                near_seg(a1x, a1y, q0x, q0y, q1x, q1y, c2) ||
                near_seg(q0x, q0y, a0x, a0y, a1x, a1y, c2) ||
                near_seg(q1x, q1y, a0x, a0y, a1x, a1y, c2))
                return 1;
            rx = a0x - a1x;
            ry = a0y - a1y;
            sx = q0x - q1x;
            sy = q0y - q1y;
            wxx = a0x - q0x;
            wyy = a0y - q0y;
            det = cross2(rx, ry, sx, sy);
            // nearly parallel never crosses
            if (det <= wx(longint'(PARALLEL_DET_MAX)) &&
                det >= -wx(longint'(PARALLEL_DET_MAX))) return 0;
            return in_span(cross2(wxx, wyy, sx, sy), det) &&
                   in_span(cross2(wxx, wyy, rx, ry), det);
        endfunction

        function void note_request(logic signed [31:0] p0x, logic signed [31:0] p0y,
                                   logic signed [31:0] p1x, logic signed [31:0] p1y,
                                   logic [CLR_W-1:0] clr);
            hit_queue.insert(hit_queue.size(), predict_hit(p0x, p0y, p1x, p1y, clr));
        endfunction

        function void check_result(logic hit);
            bit exp_hit;
            if (hit_queue.size() == 0) begin
                $display("%0t: unexpected result hit=%0b", $time, hit);
                errors++;
                return;
            end
            exp_hit = hit_queue.pop_front();
            if (hit !== exp_hit) begin
                $display("%0t: hit mismatch expected %0b actual %0b", $time, exp_hit, hit);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [COORD_W-1:0] i_lane_start_x;
    logic signed [COORD_W-1:0] i_lane_start_y;
    logic signed [COORD_W-1:0] i_lane_end_x;
    logic signed [COORD_W-1:0] i_lane_end_y;
    logic [CLR_W-1:0]          i_clearance;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic                      o_hit;
    logic                      i_cfg_we;
    t_cfg_idx                  i_cfg_index;
    logic [COORD_W-1:0]        i_cfg_data;

    hit_scoreboard sb = new();

    int  idle_pct  = 0;     // sender gap chance, percent
    int  stall_pct = 0;     // receiver stall chance, percent
    int  quiet_cycles = 0;  // watchdog count
    bit  req_taken;
    bit  rsp_taken;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    segment_envelope_intersection_core DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: random stall at each edge
    initial i_out_stall = 1'b0;
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    // handshakes are sampled mid-cycle, away from the driving edge
    always @(negedge i_clk) begin
        req_taken = i_in_valid && !o_in_stall && i_rst_n;
        rsp_taken = o_out_valid && !i_out_stall && i_rst_n;
        if (rsp_taken) sb.check_result(o_hit);
        if (rsp_taken || req_taken) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // door register write, only while the pipeline is empty
    task automatic cfg_write(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.door[idx] = val;
    endtask

    task automatic set_door(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex, logic [31:0] ey);
        cfg_write(REG_DOOR_START_X, sx);
        cfg_write(REG_DOOR_START_Y, sy);
        cfg_write(REG_DOOR_END_X, ex);
        cfg_write(REG_DOOR_END_Y, ey);
    endtask

    // send one request; called right after a rising edge
    task automatic send_request(logic [31:0] p0x, logic [31:0] p0y, logic [31:0] p1x,
                                logic [31:0] p1y, logic [CLR_W-1:0] clr);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_lane_start_x <= p0x;
        i_lane_start_y <= p0y;
        i_lane_end_x   <= p1x;
        i_lane_end_y   <= p1y;
        i_clearance    <= clr;
        forever begin
            @(negedge i_clk);
            taken = !o_in_stall;
            if (taken) sb.note_request(p0x, p0y, p1x, p1y, clr);
            @(posedge i_clk);
            if (taken) break;
        end
    endtask

    // wait for every expected result, then let the pipeline go quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.hit_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near_coord(logic [31:0] base);
        return base + ($urandom_range(0, 1 << 21) - (1 << 20));
    endfunction

    // random lane, mostly close to the door so the clearance matters
    task automatic random_request();
        logic [31:0] p0x, p0y, p1x, p1y;
        logic [CLR_W-1:0] clr;
        int mode;
        mode = $urandom_range(9);
        if (mode <= 2) begin
            p0x = $urandom; p0y = $urandom; p1x = $urandom; p1y = $urandom;
            clr = CLR_W'($urandom);
        end else begin
            p0x = near_coord(sb.door[REG_DOOR_START_X]);
            p0y = near_coord(sb.door[REG_DOOR_START_Y]);
            p1x = near_coord(sb.door[REG_DOOR_END_X]);
            p1y = near_coord(sb.door[REG_DOOR_END_Y]);
            clr = CLR_W'($urandom_range(0, 1 << 18));
            if (mode == 8) begin
                // short or point lane
                p1x = p0x + $urandom_range(0, 60);
                p1y = p0y + $urandom_range(0, 60);
            end
            if (mode == 9) clr = CLR_W'($urandom);
        end
        send_request(p0x, p0y, p1x, p1y, clr);
    endtask

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
    localparam logic [31:0] MINC = 32'h8000_0000;
    localparam logic [CLR_W-1:0] MAXCLR = '1;

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_lane_start_x = '0;
        i_lane_start_y = '0;
        i_lane_end_x   = '0;
        i_lane_end_y   = '0;
        i_clearance    = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_DOOR_START_X;
        i_cfg_data     = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // door at reset: a point at the origin
        send_request(0, 0, 0, 0, 0);
        send_request(ONE, ONE, 2 * ONE, 2 * ONE, CLR_W'(ONE));
        send_request(-ONE, ONE, ONE, -ONE, 0);
        drain();

        // directed set on a horizontal door of 10 m
        set_door(0, 0, 10 * ONE, 0);
        send_request(5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE, 0);       // proper crossing
        send_request(0, ONE, 10 * ONE, ONE, 0);                     // parallel, apart
        send_request(0, ONE, 10 * ONE, ONE, CLR_W'(ONE));           // distance equals clearance
        send_request(0, ONE, 10 * ONE, ONE, CLR_W'(ONE - 1));       // just outside
        send_request(10 * ONE, 0, 12 * ONE, 3 * ONE, 0);            // endpoints touch
        send_request(11 * ONE, 0, 15 * ONE, 0, 0);                  // collinear beyond end
        send_request(11 * ONE, 0, 15 * ONE, 0, CLR_W'(ONE));        // beyond end, within
        send_request(3 * ONE, 0, 3 * ONE, 0, 0);                    // point lane on door
        send_request(3 * ONE, 100, 3 * ONE + 64, 100, 99);          // short lane, just out
        send_request(3 * ONE, 100, 3 * ONE + 64, 100, 100);         // short lane, on edge
        send_request(-5 * ONE, 5 * ONE, 15 * ONE, -5 * ONE, 0);     // long diagonal crossing
        send_request(10 * ONE + 1, -ONE, 10 * ONE + 1, ONE, 0);     // misses end by one lsb
        send_request(MAXC, MAXC, MAXC, MAXC, 0);
        send_request(MINC, MINC, MINC, MINC, MAXCLR);
        send_request(MINC, MINC, MAXC, MAXC, 0);
        send_request(MAXC, MINC, MINC, MAXC, 0);
        send_request(MINC, MAXC, MINC, MINC, MAXCLR);
        send_request(MAXC, 5 * ONE, MAXC, -5 * ONE, MAXCLR);
        drain();

        // random phases, each with its own door and its own mix of idling and stalls
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;  stall_pct = 0;
                    set_door($urandom, $urandom, $urandom, $urandom);
                end
                1: begin
                    idle_pct = 88; stall_pct = 0;
                    set_door(MINC, MINC, MAXC, MAXC);
                end
                2: begin
                    idle_pct = 0;  stall_pct = 88;
                    set_door(ONE, ONE, ONE + 65, ONE);                 // short door
                end
                default: begin
                    idle_pct = 9;  stall_pct = 9;
                    set_door(-3 * ONE, 2 * ONE, 4 * ONE, -ONE);
                end
            endcase
            for (int n = 0; n < 400; n++) random_request();
            drain();
        end

        idle_pct = 0;
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.hit_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> segment_envelope_intersection_core.f
rtl/core/sei_pkg.sv
rtl/core/sei_front.sv
rtl/core/sei_back.sv
rtl/core/segment_envelope_intersection_core.sv
rtl/core/sei_checker.sv
dv/tb_segment_envelope_intersection_core.sv
